[rtl/core/ffra_pkg.sv]
`timescale 1ns / 1ps

package ffra_pkg;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OOM  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [20:0] CAP_RESET = 21'd1048576;

endpackage

[rtl/core/first_fit_range_allocator_unit.sv]
`timescale 1ns / 1ps
// First-fit range allocator with coalescing on free.
// Request channel (in_valid/in_ready): opcode 0 allocates length units,
// opcode 1 returns the range (start_req, length) to the free list.
// Result channel (out_valid/out_ready): status and granted_start, one
// result per request, in request order.
// The free list sits in one single-port-write, one-read memory of
// MAX_RANGES entries with registered read data; every request walks it one
// entry per cycle. An allocate stops at the first range i that fits, and
// walks on to the end of the list when that range empties and the entries
// above it shift down, or when nothing fits. A free walks the whole list;
// with the list full it first makes a counting pass and then, if the merged
// list fits, a write pass; else it reports ST_FULL.
// A finished result waits in an output register; while out_ready is low a
// new request is still taken and worked on, and its result waits until the
// output register frees.
// Reset (rst, synchronous) and a write on cfg_wr_en set the capacity and
// rebuild the list as one range (0, capacity) in state S_INIT, during which
// in_ready is low.
module first_fit_range_allocator_unit
  import ffra_pkg::*;
#(
  parameter int MAX_RANGES = 64,
  parameter int UNIT_BITS  = 20
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [UNIT_BITS:0]   cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 opcode,
  input  logic [UNIT_BITS:0]   length,
  input  logic [UNIT_BITS-1:0] start_req,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           status,
  output logic [UNIT_BITS:0]   granted_start
);

  localparam int W  = UNIT_BITS + 1;
  localparam int AW = $clog2(MAX_RANGES);
  localparam int TW = $clog2(MAX_RANGES + 1);
  localparam int KW = $clog2(MAX_RANGES + 2);

  typedef struct packed {
    logic [W-1:0] s;
    logic [W-1:0] l;
  } entry_t;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_ALLOC, S_SHIFT, S_FREE, S_DONE
  } state_t;

  function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[W] ? {W{1'b1}} : sum[W-1:0];
  endfunction

  entry_t mem [MAX_RANGES];
  entry_t q;

  state_t        state, state_next;
  logic [TW-1:0] total, total_next;
  logic [W-1:0]  cap;
  logic [TW-1:0] ri, rd_idx;
  logic          op, op_next;
  logic [W-1:0]  req_len, req_len_next;
  logic [W-1:0]  req_start, req_start_next;
  logic          placed, placed_next;
  logic          have_cur, have_cur_next;
  logic [W-1:0]  cs, cs_next;
  logic [W-1:0]  cl, cl_next;
  logic [KW-1:0] k, k_next;
  logic          commit, commit_next;
  status_t       res_status, res_status_next;
  logic [W-1:0]  res_grant, res_grant_next;
  logic          load_out;

  logic          mem_we;
  logic [AW-1:0] mem_wa;
  entry_t        mem_wd;

  logic          q_ok, ins_first, e_have, consume;
  entry_t        e;
  logic [W-1:0]  ns, nl;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    q_ok      = (ri != total);
    ins_first = !placed && (!q_ok || q.s > req_start);
    e         = ins_first ? entry_t'{s: req_start, l: req_len} : q;
    e_have    = ins_first || q_ok;
    consume   = !ins_first && q_ok;
    ns        = sat_add(q.s, req_len);
    nl        = q.l - req_len;

    state_next      = state;
    total_next      = total;
    rd_idx          = ri;
    op_next         = op;
    req_len_next    = req_len;
    req_start_next  = req_start;
    placed_next     = placed;
    have_cur_next   = have_cur;
    cs_next         = cs;
    cl_next         = cl;
    k_next          = k;
    commit_next     = commit;
    res_status_next = res_status;
    res_grant_next  = res_grant;
    load_out        = 1'b0;
    mem_we          = 1'b0;
    mem_wa          = '0;
    mem_wd          = q;

    case (state)
      S_INIT: begin
        mem_we     = 1'b1;
        mem_wa     = '0;
        mem_wd     = entry_t'{s: '0, l: cap};
        total_next = TW'(1);
        state_next = S_IDLE;
      end
      S_IDLE: begin
        rd_idx = '0;
        if (in_valid) begin
          op_next        = opcode;
          req_len_next   = length;
          req_start_next = W'(start_req);
          placed_next    = 1'b0;
          have_cur_next  = 1'b0;
          k_next         = '0;
          commit_next    = (total != TW'(MAX_RANGES));
          state_next     = (opcode == OP_FREE) ? S_FREE : S_ALLOC;
        end
      end
      S_ALLOC: begin
        if (!q_ok) begin
          res_status_next = ST_OOM;
          res_grant_next  = '0;
          state_next      = S_DONE;
        end else if (q.l >= req_len) begin
          res_status_next = ST_OK;
          res_grant_next  = q.s;
          if (nl != '0) begin
            mem_we     = 1'b1;
            mem_wa     = ri[AW-1:0];
            mem_wd     = entry_t'{s: ns, l: nl};
            state_next = S_DONE;
          end else begin
            rd_idx     = ri + TW'(1);
            state_next = S_SHIFT;
          end
        end else begin
          rd_idx = ri + TW'(1);
        end
      end
      S_SHIFT: begin
        if (!q_ok) begin
          total_next = total - TW'(1);
          state_next = S_DONE;
        end else begin
          mem_we = 1'b1;
          mem_wa = AW'(ri - TW'(1));
          mem_wd = q;
          rd_idx = ri + TW'(1);
        end
      end
      S_FREE: begin
        if (e_have) begin
          if (ins_first) begin
            placed_next = 1'b1;
          end
          if (consume) begin
            rd_idx = ri + TW'(1);
          end
          if (!have_cur) begin
            have_cur_next = 1'b1;
            cs_next       = e.s;
            cl_next       = e.l;
          end else if (({1'b0, cs} + {1'b0, cl}) == {1'b0, e.s}) begin
            cl_next = sat_add(cl, e.l);
          end else begin
            mem_we  = commit;
            mem_wa  = k[AW-1:0];
            mem_wd  = entry_t'{s: cs, l: cl};
            k_next  = k + KW'(1);
            cs_next = e.s;
            cl_next = e.l;
          end
        end else begin
          if (have_cur) begin
            mem_we = commit;
            mem_wa = k[AW-1:0];
            mem_wd = entry_t'{s: cs, l: cl};
          end
          if (commit) begin
            total_next      = TW'(k + KW'(have_cur));
            res_status_next = ST_OK;
            res_grant_next  = '0;
            state_next      = S_DONE;
          end else if (k + KW'(have_cur) > KW'(MAX_RANGES)) begin
            res_status_next = ST_FULL;
            res_grant_next  = '0;
            state_next      = S_DONE;
          end else begin
            rd_idx        = '0;
            placed_next   = 1'b0;
            have_cur_next = 1'b0;
            k_next        = '0;
            commit_next   = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    q <= mem[rd_idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      total     <= TW'(1);
      cap       <= W'(CAP_RESET);
      ri        <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= cfg_wr_en ? S_INIT : state_next;
      total     <= total_next;
      ri        <= rd_idx;
      out_valid <= (out_valid && !out_ready) || load_out;
      if (cfg_wr_en) begin
        cap <= cfg_wr_data;
      end
    end
    op         <= op_next;
    req_len    <= req_len_next;
    req_start  <= req_start_next;
    placed     <= placed_next;
    have_cur   <= have_cur_next;
    cs         <= cs_next;
    cl         <= cl_next;
    k          <= k_next;
    commit     <= commit_next;
    res_status <= res_status_next;
    res_grant  <= res_grant_next;
    if (load_out) begin
      status        <= (op == OP_ALLOC || res_status != ST_OOM) ? res_status : ST_OK;
      granted_start <= res_grant;
    end
  end

endmodule
